>>> rtl/lprip_pkg.sv
// Shared constants, types and a CORDIC step helper for the lidar range-image projector.
`timescale 1ns / 1ps
`default_nettype none

package lprip_pkg;

  // Coordinate and iteration sizing
  localparam int COORD_WIDTH      = 24;
  localparam int ANGLE_ITERATIONS = 20;

  localparam int NEU_W  = COORD_WIDTH + 1;
  localparam int MAG_W  = COORD_WIDTH;
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int ROOT_W = COORD_WIDTH;
  localparam int REM_W  = ROOT_W + 2;
  localparam int XY_W   = COORD_WIDTH + 3;

  // Angle and projection arithmetic widths
  localparam int ANG_W   = 34;
  localparam int ELEV_W  = 32;
  localparam int AZU_W   = 33;
  localparam int RING_W  = 8;
  localparam int PPR_W   = 13;
  localparam int FOV_W   = 8;
  localparam int D_W     = FOV_W + 1;
  localparam int CPROD_W = AZU_W + PPR_W;
  localparam int CQ_W    = CPROD_W - 32;
  localparam int T_W     = 41;
  localparam int NUM_W   = T_W + D_W;
  localparam int MQ_W    = 17;
  localparam int COL_W   = PPR_W + 2;

  // Result field widths
  localparam int ROW_W   = 7;
  localparam int COLI_W  = 12;
  localparam int DEPTH_W = 24;

  localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ROW_W + COLI_W + DEPTH_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PPR_W;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh0_8000_0000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [T_W-1:0]   FULL_TURN_DEG = 41'sd360;
  localparam logic [DEPTH_W-1:0]      DEPTH_MAX    = 24'hFF_FFFF;
  localparam logic [MQ_W-1:0]         ROW_LIMIT    = 17'd127;
  localparam logic signed [COL_W-1:0] COL_LIMIT    = 15'sd4095;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT      = 2'd0,
    CFG_POINTS_PER_RING = 2'd1,
    CFG_FOV_UPPER       = 2'd2,
    CFG_FOV_LOWER       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RING_W-1:0]       ring_count;
    logic [PPR_W-1:0]        points_per_ring;
    logic signed [FOV_W-1:0] fov_upper;
    logic signed [FOV_W-1:0] fov_lower;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ring_count:      8'd32,
    points_per_ring: 13'd1812,
    fov_upper:       8'sd15,
    fov_lower:       -8'sd25
  };

  // Front to back item: NEU coordinates and squared horizontal terms
  typedef struct packed {
    logic signed [NEU_W-1:0] x;
    logic signed [NEU_W-1:0] y;
    logic signed [NEU_W-1:0] z;
    logic [SQ_W-1:0]         sx;
    logic [SQ_W-1:0]         sy;
  } front_item_t;

  // Front to queue handshake
  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  typedef struct packed {
    logic [SQ_W-1:0]         rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [NEU_W-1:0] x;
    logic signed [NEU_W-1:0] y;
    logic signed [NEU_W-1:0] z;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
  } rot_t;

  typedef struct packed {
    logic [ROOT_W-1:0] h;
    rot_t              az;
    rot_t              el;
  } cd_t;

  typedef struct packed {
    logic signed [T_W-1:0] t;
    logic [CPROD_W-1:0]    cprod;
    logic [ROOT_W-1:0]     h;
  } f1_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [COL_W-1:0] col;
    logic                    col_ok;
    logic [ROOT_W-1:0]       h;
  } f2_t;

  typedef struct packed {
    logic [MQ_W-1:0]   mag;
    logic [MQ_W-1:0]   quo;
    logic [FOV_W-1:0]  rem;
    logic [FOV_W-1:0]  dv;
    logic              neg;
    logic              empty;
    logic [COLI_W-1:0] col;
    logic              col_ok;
    logic [ROOT_W-1:0] h;
  } dv_t;

  // One vectoring CORDIC step; hold once y has reached zero
  function automatic rot_t rot_step(input rot_t r, input logic [4:0] sh);
    rot_t                    o;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [ANG_W-1:0] da;
    o  = r;
    xs = r.x >>> sh;
    ys = r.y >>> sh;
    da = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[sh]});
    if (r.y > 0) begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.a = r.a + da;
    end else if (r.y < 0) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.a = r.a - da;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lprip_front.sv
// Input stage: takes points, converts NED to NEU and squares the horizontal terms.
`timescale 1ns / 1ps
`default_nettype none

module lprip_front
  import lprip_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,  // x_coord, y_coord, z_coord
  output q_ctl_t                     q_ctl,
  input  wire logic                  q_full,
  output front_item_t                f_item
);

  logic                    f_valid_r;
  front_item_t             f_item_r;
  front_item_t             f_item_nxt;
  logic signed [NEU_W-1:0] x_neu;
  logic signed [NEU_W-1:0] y_neu;
  logic signed [NEU_W-1:0] z_neu;
  logic [MAG_W-1:0]        ux;
  logic [MAG_W-1:0]        uy;

  // Negate y and z, take magnitudes and square
  always_comb begin
    x_neu = NEU_W'($signed(in_tdata[0 +: COORD_WIDTH]));
    y_neu = -NEU_W'($signed(in_tdata[COORD_WIDTH +: COORD_WIDTH]));
    z_neu = -NEU_W'($signed(in_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
    ux    = (x_neu < 0) ? MAG_W'(-x_neu) : MAG_W'(x_neu);
    uy    = (y_neu < 0) ? MAG_W'(-y_neu) : MAG_W'(y_neu);
    f_item_nxt.x  = x_neu;
    f_item_nxt.y  = y_neu;
    f_item_nxt.z  = z_neu;
    f_item_nxt.sx = SQ_W'(ux) * SQ_W'(ux);
    f_item_nxt.sy = SQ_W'(uy) * SQ_W'(uy);
  end

  assign in_tready  = !f_valid_r || !q_full;
  assign q_ctl.push = f_valid_r && !q_full;
  assign q_ctl.full = q_full;
  assign f_item     = f_item_r;

  // Hold the item until the queue has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_tready) begin
      f_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprip_fifo.sv
// Two-entry queue between the front stage and the projection pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lprip_fifo
  import lprip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  q_ctl_t           q_ctl,
  input  front_item_t      wr_item,
  output logic             full,
  output logic             rd_valid,
  input  wire logic        rd_pop,
  output front_item_t      rd_item
);

  front_item_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_push  = q_ctl.push && !q_ctl.full;
  assign do_pop   = rd_pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lprip_back.sv
// Projection pipeline: square root, two CORDICs, row divide, column and output register.
`timescale 1ns / 1ps
`default_nettype none

module lprip_back
  import lprip_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  cfg_t                        cfg,
  input  wire logic                   q_valid,
  input  front_item_t                 q_item,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // row_index, column_index, depth
  output logic                        out_tuser   // in_range
);

  localparam int SQRT_STEPS = ROOT_W;
  localparam int CD_IX      = SQRT_STEPS + 1;
  localparam int F1_IX      = CD_IX + ANGLE_ITERATIONS + 1;
  localparam int F2_IX      = F1_IX + 1;
  localparam int DV_IX      = F2_IX + 1;
  localparam int LAT        = DV_IX + MQ_W + 1;

  logic             en;
  logic [LAT-1:0]   v_r;

  sq_t sq_r   [SQRT_STEPS+1];
  sq_t sq_nxt [SQRT_STEPS+1];
  cd_t cd_r   [ANGLE_ITERATIONS+1];
  cd_t cd_nxt [ANGLE_ITERATIONS+1];
  f1_t f1_r;
  f1_t f1_nxt;
  f2_t f2_r;
  f2_t f2_nxt;
  dv_t dv_r   [MQ_W+1];
  dv_t dv_nxt [MQ_W+1];

  logic                out_valid_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COLI_W-1:0]   out_col_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic                out_ok_r;
  logic [ROW_W-1:0]    row_nxt;
  logic [COLI_W-1:0]   col_nxt;
  logic [DEPTH_W-1:0]  depth_nxt;
  logic                ok_nxt;

  // Whole pipeline moves unless a result is waiting on the output
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[LAT-2:0], q_valid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  // Sum of squares
  always_comb begin
    sq_nxt[0].rad  = q_item.sx + q_item.sy;
    sq_nxt[0].rem  = '0;
    sq_nxt[0].root = '0;
    sq_nxt[0].x    = q_item.x;
    sq_nxt[0].y    = q_item.y;
    sq_nxt[0].z    = q_item.z;
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] rem_w;
    logic [REM_W+1:0] trial;
    always_comb begin
      sq_nxt[k+1] = sq_r[k];
      rem_w = {sq_r[k].rem, sq_r[k].rad[SQ_W-1 -: 2]};
      trial = {2'b00, sq_r[k].root, 2'b01};
      if (rem_w >= trial) begin
        sq_nxt[k+1].rem  = REM_W'(rem_w - trial);
        sq_nxt[k+1].root = {sq_r[k].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt[k+1].rem  = rem_w[REM_W-1:0];
        sq_nxt[k+1].root = {sq_r[k].root[ROOT_W-2:0], 1'b0};
      end
      sq_nxt[k+1].rad = sq_r[k].rad << 2;
    end
  end

  for (genvar k = 0; k <= SQRT_STEPS; k++) begin : g_sq_reg
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
  end

  // Start both CORDICs; fold the left half-plane for azimuth
  always_comb begin
    cd_nxt[0].h    = sq_r[SQRT_STEPS].root;
    cd_nxt[0].el.x = $signed({3'b000, sq_r[SQRT_STEPS].root});
    cd_nxt[0].el.y = XY_W'(sq_r[SQRT_STEPS].z);
    cd_nxt[0].el.a = '0;
    cd_nxt[0].az.x = XY_W'(sq_r[SQRT_STEPS].x);
    cd_nxt[0].az.y = XY_W'(sq_r[SQRT_STEPS].y);
    cd_nxt[0].az.a = '0;
    if (sq_r[SQRT_STEPS].x < 0) begin
      cd_nxt[0].az.a = (sq_r[SQRT_STEPS].y > 0) ? HALF_TURN : -HALF_TURN;
      cd_nxt[0].az.x = -XY_W'(sq_r[SQRT_STEPS].x);
      cd_nxt[0].az.y = -XY_W'(sq_r[SQRT_STEPS].y);
    end
  end

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    always_comb begin
      cd_nxt[i+1].h  = cd_r[i].h;
      cd_nxt[i+1].az = rot_step(cd_r[i].az, 5'(i));
      cd_nxt[i+1].el = rot_step(cd_r[i].el, 5'(i));
    end
  end

  for (genvar i = 0; i <= ANGLE_ITERATIONS; i++) begin : g_cd_reg
    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[i] <= cd_nxt[i];
      end
    end
  end

  // Clamp angles, scale elevation, multiply azimuth by columns
  logic signed [ANG_W-1:0]  el_c;
  logic signed [ANG_W-1:0]  az_c;
  logic signed [ANG_W-1:0]  az_off;
  logic signed [ELEV_W-1:0] elev;
  logic [AZU_W-1:0]         azu;

  always_comb begin
    el_c = cd_r[ANGLE_ITERATIONS].el.a;
    if (el_c > QUARTER_TURN) begin
      el_c = QUARTER_TURN;
    end else if (el_c < -QUARTER_TURN) begin
      el_c = -QUARTER_TURN;
    end
    az_c = cd_r[ANGLE_ITERATIONS].az.a;
    if (az_c > HALF_TURN) begin
      az_c = HALF_TURN;
    end else if (az_c < -HALF_TURN) begin
      az_c = -HALF_TURN;
    end
    elev   = ELEV_W'(el_c);
    az_off = az_c + HALF_TURN;
    azu    = az_off[AZU_W-1:0];
    f1_nxt.t     = (T_W'(cfg.fov_upper) <<< 32) - T_W'(elev) * FULL_TURN_DEG;
    f1_nxt.cprod = CPROD_W'(azu) * CPROD_W'(cfg.points_per_ring);
    f1_nxt.h     = cd_r[ANGLE_ITERATIONS].h;
  end

  // Row numerator and column
  logic signed [D_W-1:0]   rm1;
  logic signed [COL_W-1:0] ppr_s;

  always_comb begin
    rm1   = $signed({1'b0, cfg.ring_count}) - 9'sd1;
    ppr_s = $signed({2'b00, cfg.points_per_ring});
    f2_nxt.num    = NUM_W'(f1_r.t) * NUM_W'(rm1);
    f2_nxt.col    = ppr_s - 15'sd1 - $signed({1'b0, f1_r.cprod[CPROD_W-1 -: CQ_W]});
    f2_nxt.col_ok = (f2_nxt.col >= 0) && (f2_nxt.col < ppr_s) && (f2_nxt.col <= COL_LIMIT);
    f2_nxt.h      = f1_r.h;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  // Split the row division into magnitude and sign
  logic signed [D_W-1:0]   dspan;
  logic signed [D_W-1:0]   dabs;
  logic signed [NUM_W-1:0] nabs;

  always_comb begin
    dspan = D_W'(cfg.fov_upper) - D_W'(cfg.fov_lower);
    dabs  = (dspan < 0) ? -dspan : dspan;
    nabs  = (f2_r.num < 0) ? -f2_r.num : f2_r.num;
    dv_nxt[0].mag    = nabs[32 +: MQ_W];
    dv_nxt[0].quo    = '0;
    dv_nxt[0].rem    = '0;
    dv_nxt[0].dv     = dabs[FOV_W-1:0];
    dv_nxt[0].neg    = f2_r.num[NUM_W-1] ^ dspan[D_W-1];
    dv_nxt[0].empty  = (dspan == '0);
    dv_nxt[0].col    = f2_r.col[COLI_W-1:0];
    dv_nxt[0].col_ok = f2_r.col_ok;
    dv_nxt[0].h      = f2_r.h;
  end

  // Restoring divide, one quotient bit per stage
  for (genvar j = 0; j < MQ_W; j++) begin : g_div
    logic [FOV_W:0] rw;
    always_comb begin
      dv_nxt[j+1] = dv_r[j];
      rw = {dv_r[j].rem, dv_r[j].mag[MQ_W-1]};
      if (rw >= {1'b0, dv_r[j].dv}) begin
        dv_nxt[j+1].rem = FOV_W'(rw - {1'b0, dv_r[j].dv});
        dv_nxt[j+1].quo = {dv_r[j].quo[MQ_W-2:0], 1'b1};
      end else begin
        dv_nxt[j+1].rem = rw[FOV_W-1:0];
        dv_nxt[j+1].quo = {dv_r[j].quo[MQ_W-2:0], 1'b0};
      end
      dv_nxt[j+1].mag = dv_r[j].mag << 1;
    end
  end

  for (genvar j = 0; j <= MQ_W; j++) begin : g_dv_reg
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Window test and result fields
  logic row_ok;

  always_comb begin
    row_ok = !dv_r[MQ_W].empty
          && !(dv_r[MQ_W].neg && (dv_r[MQ_W].quo != '0))
          && (dv_r[MQ_W].quo < MQ_W'(cfg.ring_count))
          && (dv_r[MQ_W].quo <= ROW_LIMIT);
    ok_nxt    = row_ok && dv_r[MQ_W].col_ok;
    row_nxt   = ok_nxt ? dv_r[MQ_W].quo[ROW_W-1:0] : '0;
    col_nxt   = ok_nxt ? dv_r[MQ_W].col : '0;
    depth_nxt = (dv_r[MQ_W].h > ROOT_W'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(dv_r[MQ_W].h);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_row_r   <= row_nxt;
      out_col_r   <= col_nxt;
      out_depth_r <= depth_nxt;
      out_ok_r    <= ok_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_depth_r, out_col_r, out_row_r});
  assign out_tuser  = out_ok_r;

`ifndef SYNTH
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_row_r == '0 && out_col_r == '0))
    else $error("out-of-window result carries non-zero indices");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(v_r) && $stable(out_tdata)))
    else $error("pipeline moved while the output was stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAT-1] && en) |=> out_valid_r)
    else $error("last pipeline stage lost a transaction");
`endif

endmodule

`default_nettype wire

>>> rtl/lidar_point_range_image_projection_top.sv
// Top level of the lidar point to range-image projector.
`timescale 1ns / 1ps
`default_nettype none

// Projects each lidar point (x, y, z, NED, 1/1024 m) onto a range image and
// returns row, column, horizontal depth and an in-range flag, one result per
// point, in order. One point is accepted per clock cycle while the output is
// not stalled. A point passes in order through the front register that
// squares the horizontal terms, the two-entry queue, the sum of squares, one
// bit of square root per stage (24), the CORDIC set-up and one iteration per
// stage for elevation and azimuth side by side (20), two scaling stages, the
// divide set-up and one quotient bit per stage for the row divide (17), then
// the output register. A stalled output holds the whole pipeline; the queue
// then fills and the input stalls. Configuration registers are written
// through cfg_we/cfg_index/cfg_wdata and must only change while no point is
// in flight.
module lidar_point_range_image_projection_top
  import lprip_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // x_coord, y_coord, z_coord
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // row_index, column_index, depth
  output logic                        out_tuser,  // in_range
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t        cfg_r;
  q_ctl_t      q_ctl;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  front_item_t f_item;
  front_item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RING_COUNT:      cfg_r.ring_count      <= cfg_wdata[RING_W-1:0];
        CFG_POINTS_PER_RING: cfg_r.points_per_ring <= cfg_wdata[PPR_W-1:0];
        CFG_FOV_UPPER:       cfg_r.fov_upper       <= $signed(cfg_wdata[FOV_W-1:0]);
        CFG_FOV_LOWER:       cfg_r.fov_lower       <= $signed(cfg_wdata[FOV_W-1:0]);
        default: ;
      endcase
    end
  end

  lprip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ctl     (q_ctl),
    .q_full    (q_full),
    .f_item    (f_item)
  );

  lprip_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_ctl    (q_ctl),
    .wr_item  (f_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  lprip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the lidar point range-image projector.
`timescale 1ns / 1ps

module tb;
  import lprip_pkg::*;

  localparam int RUN_LIMIT = 400000;

  typedef struct {
    logic [ROW_W-1:0]   row;
    logic [COLI_W-1:0]  col;
    logic [DEPTH_W-1:0] depth;
    logic               flag;
  } proj_t;

  // Projection predictor with its own register copy and queue of pending projections
  class proj_scoreboard;
    proj_t  pending_q[$];
    int     errors;
    longint rings, cols, fov_up, fov_lo;

    function new();
      errors = 0;
      rings  = 32;
      cols   = 1812;
      fov_up = 15;
      fov_lo = -25;
    endfunction

    function void configure(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RING_COUNT:      rings  = longint'(val[7:0]);
        CFG_POINTS_PER_RING: cols   = longint'(val);
        CFG_FOV_UPPER:       fov_up = longint'($signed(val[7:0]));
        CFG_FOV_LOWER:       fov_lo = longint'($signed(val[7:0]));
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Vectoring CORDIC in binary angle units, 2^32 per turn
    function longint vector_angle(longint x, longint y);
      longint a, xs, ys;
      a = 0;
      if (x < 0) begin
        a = (y > 0) ? 64'sd2147483648 : -64'sd2147483648;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
        if (y == 0) break;
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          a = a + longint'(ATAN_TAB[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          a = a - longint'(ATAN_TAB[i]);
        end
      end
      return a;
    endfunction

    function void note_point(logic signed [23:0] xc, logic signed [23:0] yc,
                             logic signed [23:0] zc);
      longint          x, y, z, elev, azim, row, col, num;
      longint unsigned ux, uy, h, q;
      bit              ok;
      proj_t           p;
      x  = longint'(xc);
      y  = -longint'(yc);
      z  = -longint'(zc);
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      h  = int_sqrt(ux * ux + uy * uy);
      elev = vector_angle(longint'(h), z);
      azim = vector_angle(x, y);
      if (elev > 64'sd1073741824) elev = 64'sd1073741824;
      if (elev < -64'sd1073741824) elev = -64'sd1073741824;
      if (azim > 64'sd2147483648) azim = 64'sd2147483648;
      if (azim < -64'sd2147483648) azim = -64'sd2147483648;
      ok  = 1;
      row = 0;
      if (fov_up == fov_lo) begin
        ok = 0;
      end else begin
        num = (fov_up * 64'sd4294967296 - 360 * elev) * (rings - 1);
        row = num / ((fov_up - fov_lo) * 64'sd4294967296);
        if (row < 0 || row >= rings || row > 127) ok = 0;
      end
      q   = (longint'(azim + 64'sd2147483648) * cols) >> 32;
      col = (cols - 1) - longint'(q);
      if (col < 0 || col >= cols || col > 4095) ok = 0;
      p.row   = ok ? row[6:0] : '0;
      p.col   = ok ? col[11:0] : '0;
      p.depth = (h > 64'd16777215) ? DEPTH_MAX : h[23:0];
      p.flag  = ok;
      pending_q.insert(pending_q.size(), p);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(proj_t got);
      proj_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending_q.pop_front();
      if (got.row !== want.row)
        report($sformatf("row %0d, predicted %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("column %0d, predicted %0d", got.col, want.col));
      if (got.depth !== want.depth)
        report($sformatf("depth %0d, predicted %0d", got.depth, want.depth));
      if (got.flag !== want.flag)
        report($sformatf("in_range %0b, predicted %0b", got.flag, want.flag));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    cfg_we;
  cfg_idx_t                cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  proj_scoreboard sb;
  int  idle_in_pct;
  int  idle_out_pct;
  int  hold_len  = 0;
  int  hold_gen  = 0;
  int  hold_seen = 0;
  int  hold_off  = 0;
  int  cycles    = 0;

  lidar_point_range_image_projection_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive the result ready: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen  <= hold_gen;
      hold_off   <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off   <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_out_pct);
    end
  end

  // Check each result transaction
  always @(posedge clk) begin
    proj_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.row   = out_tdata[6:0];
      got.col   = out_tdata[18:7];
      got.depth = out_tdata[42:19];
      got.flag  = out_tuser;
      sb.check_result(got);
    end
  end

  // Ask the receiver process to hold off for a number of cycles
  task automatic hold_receiver(int n);
    hold_len = n;
    hold_gen++;
  endtask

  // Offer one point and hold it until the transaction completes
  task automatic send_point(logic [23:0] xc, logic [23:0] yc, logic [23:0] zc);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {xc, yc, zc} == 72'h0 ? '0 : {zc, yc, xc};
    do @(posedge clk); while (!in_tready);
    sb.note_point(xc, yc, zc);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.configure(idx, val);
  endtask

  task automatic set_view(int rings, int cols, int up, int lo);
    write_reg(CFG_RING_COUNT, CFG_DATA_W'(rings));
    write_reg(CFG_POINTS_PER_RING, CFG_DATA_W'(cols));
    write_reg(CFG_FOV_UPPER, CFG_DATA_W'(up & 8'hFF));
    write_reg(CFG_FOV_LOWER, CFG_DATA_W'(lo & 8'hFF));
  endtask

  function automatic logic [23:0] rand_coord();
    int span;
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'h0;
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: begin
        span = 1 << $urandom_range(4, 22);
        return 24'($signed($urandom_range(0, 2 * span)) - span);
      end
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_RING_COUNT;
    cfg_wdata    = '0;
    idle_in_pct  = 24;
    idle_out_pct = 71;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed points under the reset view: origin, axes, extremes, clamps
    send_point(24'h0, 24'h0, 24'h0);
    send_point(24'h000400, 24'h0, 24'h0);
    send_point(24'hFFFC00, 24'h0, 24'h0);
    send_point(24'h800000, 24'h0, 24'h0);
    send_point(24'h0, 24'h000400, 24'h0);
    send_point(24'h0, 24'hFFFC00, 24'h0);
    send_point(24'h0, 24'h0, 24'h7FFFFF);
    send_point(24'h0, 24'h0, 24'h800000);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7FFFFF, 24'h800000, 24'h0);
    send_point(24'h800000, 24'h7FFFFF, 24'h000001);
    send_point(24'h002800, 24'h001000, 24'hFFF800);
    send_point(24'h002800, 24'hFFF000, 24'h000800);
    send_point(24'hFFD800, 24'h000001, 24'h0);
    send_point(24'hFFD800, 24'hFFFFFF, 24'h0);
    send_point(24'h000001, 24'h000001, 24'h000001);
    send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_random(440);
    wait_drained();

    // Fewest rows and columns, widest field
    set_view(2, 1, 90, -90);
    send_random(300);
    wait_drained();

    // Sender idles more than the receiver; the receiver holds off for a stretch
    idle_in_pct  = 71;
    idle_out_pct = 24;
    set_view(128, 4096, -90, 90);
    hold_receiver(400);
    send_random(300);
    wait_drained();

    // Empty field of view
    set_view(128, 4096, 10, 10);
    send_random(100);
    wait_drained();

    // No idling at all, with a full-rate hold-off
    idle_in_pct  = 0;
    idle_out_pct = 0;
    set_view(64, 2048, 2, -30);
    hold_receiver(300);
    send_random(300);
    wait_drained();

    // Random views
    for (int k = 0; k < 4; k++) begin
      set_view($urandom_range(2, 128), $urandom_range(1, 4096),
               $signed($urandom_range(0, 180)) - 90, $signed($urandom_range(0, 180)) - 90);
      send_random(100);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
